[rtl/asc_pkg.sv]
// Shared types and constants for the alignment identity scorer.
// Holds the item kinds, the controller-to-datapath command and status
// structs and the divider sizing; depends on nothing else.
package asc_pkg;

  // Default counter width for the per-exon and per-alignment tallies.
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed widths of the result fields.
  localparam int TOTAL_W = 32;
  localparam int PCT_ID_W = 8;
  localparam int PCT_COV_W = 16;

  // Quotient bits produced by the shared divider for each ratio.
  localparam int ID_QBITS = 8;
  localparam int COV_QBITS = 16;
  localparam int STEP_W = $clog2(COV_QBITS + 2);

  // Identity is 100 minus an edit penalty that is capped at 200.
  localparam int ID_MAX_PCT = 100;
  localparam int ID_PENALTY_MAX = 200;

  typedef enum logic [1:0] {
    KIND_COLUMN = 2'd0,
    KIND_EXON   = 2'd1,
    KIND_ALIGN  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CLS_GAP    = 3'd0,
    CLS_BOTH_N = 3'd1,
    CLS_ONE_N  = 3'd2,
    CLS_MATCH  = 3'd3,
    CLS_SUBST  = 3'd4
  } col_class_t;

  typedef struct packed {
    logic col_load;
    logic exon_load;
    logic align_load;
    logic id_setup;
    logic cov_setup;
    logic div_step;
    logic id_store;
    logic cov_store;
  } asc_cmd_t;

  typedef struct packed {
    logic div_last;
  } asc_sts_t;

endpackage

[rtl/asc_ctrl.sv]
// Sequencing state machine of the alignment identity scorer.
// Drives the input stall, the result valid and the datapath commands;
// uses asc_pkg for the command and status structs.
module asc_ctrl
  import asc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_kind,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output asc_cmd_t cmd,
  input  asc_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ID_SETUP,
    ST_ID_RUN,
    ST_ID_FIN,
    ST_COV_RUN,
    ST_COV_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_align_r, is_align_nxt;
  logic   out_free;
  logic   accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    is_align_nxt  = is_align_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(in_kind))
            KIND_COLUMN: begin
              cmd.col_load  = 1'b1;
              out_valid_nxt = 1'b1;
            end
            KIND_EXON: begin
              cmd.exon_load = 1'b1;
              is_align_nxt  = 1'b0;
              state_nxt     = ST_ID_SETUP;
            end
            KIND_ALIGN: begin
              cmd.align_load = 1'b1;
              is_align_nxt   = 1'b1;
              state_nxt      = ST_ID_SETUP;
            end
            KIND_NONE: begin
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ID_SETUP: begin
        cmd.id_setup = 1'b1;
        state_nxt    = ST_ID_RUN;
      end
      ST_ID_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_ID_FIN;
        end
      end
      ST_ID_FIN: begin
        cmd.id_store = 1'b1;
        if (is_align_r) begin
          cmd.cov_setup = 1'b1;
          state_nxt     = ST_COV_RUN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_COV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_COV_FIN;
        end
      end
      ST_COV_FIN: begin
        cmd.cov_store = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      is_align_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      is_align_r  <= is_align_nxt;
    end
  end

  // A column transfer always yields a result on the next cycle.
  a_col_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_COLUMN) |=> out_valid_r)
    else $error("column item did not raise a result");

  // A close item keeps the result channel quiet while the divider runs.
  a_close_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((in_kind == KIND_EXON) || (in_kind == KIND_ALIGN)) |=> !out_valid_r)
    else $error("result shown before the close item was finished");

  // The identity result is only stored after the divider has run.
  a_id_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ID_FIN) |-> ($past(state_r) == ST_ID_RUN))
    else $error("identity stored without a division pass");

endmodule

[rtl/asc_datapath.sv]
// Datapath of the alignment identity scorer: column classifier, tallies,
// close-item operands, shared restoring divider and the result register.
// Uses asc_pkg for the command and status structs and the divider sizing.
module asc_datapath
  import asc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asc_cmd_t                    cmd,
  output asc_sts_t                    sts,
  input  logic [7:0]                  in_query_char,
  input  logic [7:0]                  in_genome_char,
  input  logic [31:0]                 in_genome_from,
  input  logic [31:0]                 in_genome_to,
  input  logic [31:0]                 in_query_from,
  input  logic [31:0]                 in_query_to,
  input  logic [31:0]                 in_query_length,
  input  logic [31:0]                 in_poly_a_length,
  input  logic [31:0]                 in_poly_t_length,
  output logic [1:0]                  out_result_kind,
  output logic [2:0]                  out_column_class,
  output logic [7:0]                  out_query_char_out,
  output logic [7:0]                  out_genome_char_out,
  output logic [TOTAL_W-1:0]          out_match_total,
  output logic [TOTAL_W-1:0]          out_n_match_total,
  output logic [TOTAL_W-1:0]          out_covered_total,
  output logic signed [PCT_ID_W-1:0]  out_identity_percent,
  output logic [PCT_COV_W-1:0]        out_coverage_percent,
  output logic                        out_coverage_invalid
);

  // Spans are 34-bit signed; widen to the counter width when it is larger.
  localparam int EXT_W = (COUNT_WIDTH > 34) ? COUNT_WIDTH : 34;
  // Room for 400 times an edit count, and for a 34-bit divisor shifted
  // past the widest quotient.
  localparam int DIV_W = (COUNT_WIDTH + 17 > 51) ? COUNT_WIDTH + 17 : 51;

  localparam logic [7:0] CH_GAP = 8'h2D;
  localparam logic [7:0] CH_N_UP = 8'h4E;
  localparam logic [7:0] CH_N_LO = 8'h6E;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
  endfunction

  // IUPAC code to its set of bases: bit 0 A, bit 1 C, bit 2 G, bit 3 T.
  function automatic logic [3:0] base_set(input logic [7:0] c);
    logic [7:0] u;
    u = to_upper(c);
    case (u)
      "A":      return 4'd1;
      "C":      return 4'd2;
      "G":      return 4'd4;
      "T", "U": return 4'd8;
      "R":      return 4'd5;
      "Y":      return 4'd10;
      "S":      return 4'd6;
      "W":      return 4'd9;
      "K":      return 4'd12;
      "M":      return 4'd3;
      "B":      return 4'd14;
      "D":      return 4'd13;
      "H":      return 4'd11;
      "V":      return 4'd7;
      "N":      return 4'd15;
      default:  return 4'd0;
    endcase
  endfunction

  // Tallies.
  logic [COUNT_WIDTH-1:0] exon_edits_r, exon_nm_r, exon_m_r;
  logic [COUNT_WIDTH-1:0] tot_edits_r, tot_nm_r, tot_m_r, tot_len_r, tot_cov_r;

  // Operands held for the divider.
  logic [COUNT_WIDTH-1:0] op_e_r, op_len_r, op_cov_r;
  logic signed [34:0]     op_den_r;

  // Shared divider.
  logic [DIV_W-1:0]     rem_r, dvs_r;
  logic [COV_QBITS:0]   quo_r;
  logic [STEP_W-1:0]    step_r;

  // Result register.
  logic [1:0]                 res_kind_r;
  logic [2:0]                 res_class_r;
  logic [7:0]                 res_q_r, res_g_r;
  logic [TOTAL_W-1:0]         res_m_r, res_nm_r, res_cov_tot_r;
  logic signed [PCT_ID_W-1:0] res_id_r;
  logic [PCT_COV_W-1:0]       res_cov_r;
  logic                       res_inv_r;

  // Column classification.
  logic       is_gap, q_is_n, g_is_n, iupac_hit;
  col_class_t col_cls;
  logic [7:0] q_case, g_case;

  always_comb begin
    is_gap    = (in_query_char == CH_GAP) || (in_genome_char == CH_GAP);
    q_is_n    = (in_query_char == CH_N_UP) || (in_query_char == CH_N_LO);
    g_is_n    = (in_genome_char == CH_N_UP) || (in_genome_char == CH_N_LO);
    iupac_hit = |(base_set(in_query_char) & base_set(in_genome_char));
    if (is_gap) begin
      col_cls = CLS_GAP;
    end else if (q_is_n && g_is_n) begin
      col_cls = CLS_BOTH_N;
    end else if (q_is_n || g_is_n) begin
      col_cls = CLS_ONE_N;
    end else if (iupac_hit) begin
      col_cls = CLS_MATCH;
    end else begin
      col_cls = CLS_SUBST;
    end
    q_case = (col_cls == CLS_MATCH) ? to_lower(in_query_char) : to_upper(in_query_char);
    g_case = (col_cls == CLS_MATCH) ? to_lower(in_genome_char) : to_upper(in_genome_char);
  end

  // Exon spans and length, alignment coverage denominator.
  logic signed [33:0]      span_g, span_q;
  logic signed [EXT_W-1:0] span_g_ext, span_q_ext;
  logic [COUNT_WIDTH-1:0]  span_g_c, span_q_c, exon_len;
  logic signed [34:0]      cov_den;

  always_comb begin
    span_g     = $signed({2'b00, in_genome_to}) - $signed({2'b00, in_genome_from}) + 34'sd1;
    span_q     = $signed({2'b00, in_query_to}) - $signed({2'b00, in_query_from}) + 34'sd1;
    span_g_ext = EXT_W'(span_g);
    span_q_ext = EXT_W'(span_q);
    span_g_c   = span_g_ext[COUNT_WIDTH-1:0];
    span_q_c   = span_q_ext[COUNT_WIDTH-1:0];
    exon_len   = span_g_c + span_q_c + exon_edits_r;
    cov_den    = $signed({3'b000, in_query_length}) - $signed({3'b000, in_poly_a_length})
               - $signed({3'b000, in_poly_t_length});
  end

  // Divider set-up values and the per-step compare.
  logic                       len_pos, den_pos;
  logic [DIV_W-1:0]           id_e_w, id_len_w, id_num, id_dvs;
  logic [DIV_W-1:0]           cov_c_w, cov_den_w, cov_num, cov_dvs;
  logic                       rem_ge;
  logic [DIV_W-1:0]           rem_sub;
  logic [ID_QBITS-1:0]        id_quo;
  logic signed [PCT_ID_W-1:0] id_pct;
  logic [PCT_COV_W-1:0]       cov_pct;
  logic                       cov_inv;

  always_comb begin
    len_pos   = !op_len_r[COUNT_WIDTH-1] && (op_len_r != '0);
    den_pos   = !op_den_r[34] && (op_den_r != '0);
    // Edit penalty: floor((400*edits + len - 1) / (2*len)).
    id_e_w    = DIV_W'(op_e_r);
    id_len_w  = DIV_W'(op_len_r);
    id_num    = (id_e_w << 8) + (id_e_w << 7) + (id_e_w << 4) + id_len_w - DIV_W'(1);
    id_dvs    = id_len_w << (ID_QBITS + 1);
    // Coverage: floor((200*covered + den) / (2*den)).
    cov_c_w   = DIV_W'(op_cov_r);
    cov_den_w = DIV_W'(op_den_r[32:0]);
    cov_num   = (cov_c_w << 7) + (cov_c_w << 6) + (cov_c_w << 3) + cov_den_w;
    cov_dvs   = cov_den_w << (COV_QBITS + 1);
    rem_ge    = rem_r >= dvs_r;
    rem_sub   = rem_r - dvs_r;

    id_quo = quo_r[ID_QBITS-1:0];
    if (!len_pos) begin
      id_pct = '0;
    end else if (quo_r[ID_QBITS] || (int'(id_quo) > ID_PENALTY_MAX)) begin
      id_pct = PCT_ID_W'(-ID_MAX_PCT);
    end else begin
      id_pct = PCT_ID_W'(ID_MAX_PCT - int'(id_quo));
    end

    cov_inv = !den_pos;
    if (!den_pos || op_cov_r[COUNT_WIDTH-1]) begin
      cov_pct = '0;
    end else if (quo_r[COV_QBITS]) begin
      cov_pct = '1;
    end else begin
      cov_pct = quo_r[COV_QBITS-1:0];
    end
  end

  assign sts.div_last = (step_r == STEP_W'(1));

  // Tallies and the divider step count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exon_edits_r <= '0;
      exon_nm_r    <= '0;
      exon_m_r     <= '0;
      tot_edits_r  <= '0;
      tot_nm_r     <= '0;
      tot_m_r      <= '0;
      tot_len_r    <= '0;
      tot_cov_r    <= '0;
      step_r       <= '0;
    end else begin
      if (cmd.col_load) begin
        case (col_cls) inside
          CLS_GAP, CLS_ONE_N, CLS_SUBST: exon_edits_r <= exon_edits_r + 1'b1;
          CLS_BOTH_N:                    exon_nm_r <= exon_nm_r + 1'b1;
          CLS_MATCH:                     exon_m_r <= exon_m_r + 1'b1;
          default:                       exon_edits_r <= exon_edits_r;
        endcase
      end
      if (cmd.exon_load) begin
        tot_edits_r  <= tot_edits_r + exon_edits_r;
        tot_nm_r     <= tot_nm_r + exon_nm_r;
        tot_m_r      <= tot_m_r + exon_m_r;
        tot_len_r    <= tot_len_r + exon_len;
        tot_cov_r    <= tot_cov_r + span_g_c;
        exon_edits_r <= '0;
        exon_nm_r    <= '0;
        exon_m_r     <= '0;
      end
      if (cmd.align_load) begin
        tot_edits_r <= '0;
        tot_nm_r    <= '0;
        tot_m_r     <= '0;
        tot_len_r   <= '0;
        tot_cov_r   <= '0;
      end
      if (cmd.id_setup) begin
        step_r <= STEP_W'(ID_QBITS + 1);
      end else if (cmd.cov_setup) begin
        step_r <= STEP_W'(COV_QBITS + 1);
      end else if (cmd.div_step) begin
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Operands, divider and result register.
  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      res_kind_r    <= KIND_COLUMN;
      res_class_r   <= col_cls;
      res_q_r       <= q_case;
      res_g_r       <= g_case;
      res_m_r       <= '0;
      res_nm_r      <= '0;
      res_cov_tot_r <= '0;
      res_id_r      <= '0;
      res_cov_r     <= '0;
      res_inv_r     <= 1'b0;
    end
    if (cmd.exon_load) begin
      res_kind_r    <= KIND_EXON;
      res_class_r   <= '0;
      res_q_r       <= '0;
      res_g_r       <= '0;
      res_m_r       <= TOTAL_W'(exon_m_r);
      res_nm_r      <= TOTAL_W'(exon_nm_r);
      res_cov_tot_r <= '0;
      res_cov_r     <= '0;
      res_inv_r     <= 1'b0;
      op_e_r        <= exon_edits_r;
      op_len_r      <= exon_len;
    end
    if (cmd.align_load) begin
      res_kind_r    <= KIND_ALIGN;
      res_class_r   <= '0;
      res_q_r       <= '0;
      res_g_r       <= '0;
      res_m_r       <= TOTAL_W'(tot_m_r);
      res_nm_r      <= TOTAL_W'(tot_nm_r);
      res_cov_tot_r <= TOTAL_W'(tot_cov_r);
      op_e_r        <= tot_edits_r;
      op_len_r      <= tot_len_r;
      op_cov_r      <= tot_cov_r;
      op_den_r      <= cov_den;
    end
    if (cmd.id_setup) begin
      rem_r <= id_num;
      dvs_r <= id_dvs;
      quo_r <= '0;
    end else if (cmd.cov_setup) begin
      rem_r <= cov_num;
      dvs_r <= cov_dvs;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_sub;
      end
      quo_r <= {quo_r[COV_QBITS-1:0], rem_ge};
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.id_store) begin
      res_id_r <= id_pct;
    end
    if (cmd.cov_store) begin
      res_cov_r <= cov_pct;
      res_inv_r <= cov_inv;
    end
  end

  assign out_result_kind      = res_kind_r;
  assign out_column_class     = res_class_r;
  assign out_query_char_out   = res_q_r;
  assign out_genome_char_out  = res_g_r;
  assign out_match_total      = res_m_r;
  assign out_n_match_total    = res_nm_r;
  assign out_covered_total    = res_cov_tot_r;
  assign out_identity_percent = res_id_r;
  assign out_coverage_percent = res_cov_r;
  assign out_coverage_invalid = res_inv_r;

  // Closing an exon hands its tallies on and starts the next exon at zero.
  a_exon_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exon_load |=> (exon_edits_r == '0) && (exon_nm_r == '0) && (exon_m_r == '0))
    else $error("exon tallies not cleared at exon close");

  // Closing the alignment clears the running length and coverage.
  a_align_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.align_load |=> (tot_len_r == '0) && (tot_cov_r == '0))
    else $error("alignment totals not cleared at alignment close");

endmodule

[rtl/alignment_identity_scorer_core.sv]
// Alignment identity scorer, top level. A column item gives its result in the
// cycle after its transfer, so columns stream at one item per cycle while the
// result channel does not stall. Exon and alignment closes stall new items
// until their result is shown; the shared restoring divider yields one quotient
// bit a cycle, 9 steps for identity and 17 more for coverage. Reset (rst_n,
// active low, synchronous) clears all tallies and leaves the block idle.
module alignment_identity_scorer_core
  import asc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Item input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_query_char,
  input  logic [7:0]                  in_genome_char,
  input  logic [31:0]                 in_genome_from,
  input  logic [31:0]                 in_genome_to,
  input  logic [31:0]                 in_query_from,
  input  logic [31:0]                 in_query_to,
  input  logic [31:0]                 in_query_length,
  input  logic [31:0]                 in_poly_a_length,
  input  logic [31:0]                 in_poly_t_length,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_result_kind,
  output logic [2:0]                  out_column_class,
  output logic [7:0]                  out_query_char_out,
  output logic [7:0]                  out_genome_char_out,
  output logic [TOTAL_W-1:0]          out_match_total,
  output logic [TOTAL_W-1:0]          out_n_match_total,
  output logic [TOTAL_W-1:0]          out_covered_total,
  output logic signed [PCT_ID_W-1:0]  out_identity_percent,
  output logic [PCT_COV_W-1:0]        out_coverage_percent,
  output logic                        out_coverage_invalid
);

  // The controller decides when a transfer is taken on either channel and
  // steps the datapath through the close items; the datapath holds every
  // tally, the divider and the result register, which keeps a finished
  // result steady while the far side stalls. A new item is taken in the
  // same cycle as the waiting result is transferred out.
  asc_cmd_t cmd;
  asc_sts_t sts;

  asc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Percent identity is 100 minus a rounded edit penalty, and coverage is
  // the rounded ratio of covered bases to the query length less its poly-A
  // and poly-T stretches; both are exact integer divisions with saturation.
  asc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_query_char        (in_query_char),
    .in_genome_char       (in_genome_char),
    .in_genome_from       (in_genome_from),
    .in_genome_to         (in_genome_to),
    .in_query_from        (in_query_from),
    .in_query_to          (in_query_to),
    .in_query_length      (in_query_length),
    .in_poly_a_length     (in_poly_a_length),
    .in_poly_t_length     (in_poly_t_length),
    .out_result_kind      (out_result_kind),
    .out_column_class     (out_column_class),
    .out_query_char_out   (out_query_char_out),
    .out_genome_char_out  (out_genome_char_out),
    .out_match_total      (out_match_total),
    .out_n_match_total    (out_n_match_total),
    .out_covered_total    (out_covered_total),
    .out_identity_percent (out_identity_percent),
    .out_coverage_percent (out_coverage_percent),
    .out_coverage_invalid (out_coverage_invalid)
  );

endmodule

[bench/asc_score_checker.sv]
// Result checker for the alignment identity scorer: watches both channels,
// predicts every result from the accepted items and compares it field by field.
// Depends on asc_pkg for the item kinds, column classes and field widths.
`timescale 1ns / 1ps

module asc_score_checker
  import asc_pkg::*;
#(
  parameter int CW = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_query_char,
  input  logic [7:0]                 in_genome_char,
  input  logic [31:0]                in_genome_from,
  input  logic [31:0]                in_genome_to,
  input  logic [31:0]                in_query_from,
  input  logic [31:0]                in_query_to,
  input  logic [31:0]                in_query_length,
  input  logic [31:0]                in_poly_a_length,
  input  logic [31:0]                in_poly_t_length,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_result_kind,
  input  logic [2:0]                 out_column_class,
  input  logic [7:0]                 out_query_char_out,
  input  logic [7:0]                 out_genome_char_out,
  input  logic [TOTAL_W-1:0]         out_match_total,
  input  logic [TOTAL_W-1:0]         out_n_match_total,
  input  logic [TOTAL_W-1:0]         out_covered_total,
  input  logic signed [PCT_ID_W-1:0] out_identity_percent,
  input  logic [PCT_COV_W-1:0]       out_coverage_percent,
  input  logic                       out_coverage_invalid,
  output int                         fail_count,
  output int                         pending,
  output int                         results_seen
);

  typedef struct {
    kind_t                kind;
    col_class_t           cls;
    logic [7:0]           q_chr;
    logic [7:0]           g_chr;
    logic [TOTAL_W-1:0]   match_cnt;
    logic [TOTAL_W-1:0]   n_matches;
    logic [TOTAL_W-1:0]   covered;
    logic [PCT_ID_W-1:0]  identity;
    logic [PCT_COV_W-1:0] coverage;
    logic                 cov_bad;
  } score_t;

  score_t score_q[$];
  score_t want;

  logic [CW-1:0] ex_edits, ex_n_match, ex_match;
  logic [CW-1:0] tot_edits, tot_n_match, tot_match, tot_len, tot_cov;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic logic [7:0] upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // IUPAC code to its set of bases: bit 0 A, bit 1 C, bit 2 G, bit 3 T/U.
  function automatic logic [3:0] base_mask(logic [7:0] c);
    case (upper(c))
      "A": return 4'd1;
      "C": return 4'd2;
      "G": return 4'd4;
      "T", "U": return 4'd8;
      "R": return 4'd5;
      "Y": return 4'd10;
      "S": return 4'd6;
      "W": return 4'd9;
      "K": return 4'd12;
      "M": return 4'd3;
      "B": return 4'd14;
      "D": return 4'd13;
      "H": return 4'd11;
      "V": return 4'd7;
      "N": return 4'd15;
      default: return 4'd0;
    endcase
  endfunction

  function automatic longint sext(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  // Floor division for a positive divisor.
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic [PCT_ID_W-1:0] identity_pct(logic [CW-1:0] edits, longint len);
    longint r;
    if (len <= 0) return '0;
    r = floor_div(200 * (len - 2 * longint'(edits)) + len, 2 * len);
    if (r > 100) r = 100;
    if (r < -100) r = -100;
    return r[PCT_ID_W-1:0];
  endfunction

  // Works out the result of the item on the input ports and advances the tallies.
  function automatic score_t predict_score();
    score_t        s;
    logic [7:0]    q, g;
    logic          qn, gn;
    longint        sg, sq, den, r;
    logic [CW-1:0] al;
    s.kind      = kind_t'(in_kind);
    s.cls       = CLS_GAP;
    s.q_chr     = '0;
    s.g_chr     = '0;
    s.match_cnt = '0;
    s.n_matches = '0;
    s.covered   = '0;
    s.identity  = '0;
    s.coverage  = '0;
    s.cov_bad   = 1'b0;
    case (s.kind)
      KIND_COLUMN: begin
        q  = in_query_char;
        g  = in_genome_char;
        qn = (q == "N" || q == "n");
        gn = (g == "N" || g == "n");
        if (q == "-" || g == "-") begin
          s.cls = CLS_GAP;
          ex_edits++;
        end else if (qn && gn) begin
          s.cls = CLS_BOTH_N;
          ex_n_match++;
        end else if (qn || gn) begin
          s.cls = CLS_ONE_N;
          ex_edits++;
        end else if ((base_mask(q) & base_mask(g)) != 0) begin
          s.cls = CLS_MATCH;
          ex_match++;
        end else begin
          s.cls = CLS_SUBST;
          ex_edits++;
        end
        s.q_chr = (s.cls == CLS_MATCH) ? lower(q) : upper(q);
        s.g_chr = (s.cls == CLS_MATCH) ? lower(g) : upper(g);
      end
      KIND_EXON: begin
        sg = longint'(in_genome_to) - longint'(in_genome_from) + 1;
        sq = longint'(in_query_to) - longint'(in_query_from) + 1;
        al = CW'(sg + sq + longint'(ex_edits));
        s.match_cnt = TOTAL_W'(ex_match);
        s.n_matches = TOTAL_W'(ex_n_match);
        s.identity  = identity_pct(ex_edits, sext(al));
        tot_edits   = tot_edits + ex_edits;
        tot_n_match = tot_n_match + ex_n_match;
        tot_match   = tot_match + ex_match;
        tot_len     = tot_len + al;
        tot_cov     = tot_cov + sg[CW-1:0];
        ex_edits    = '0;
        ex_n_match  = '0;
        ex_match    = '0;
      end
      default: begin
        den = longint'(in_query_length) - longint'(in_poly_a_length)
            - longint'(in_poly_t_length);
        s.match_cnt = TOTAL_W'(tot_match);
        s.n_matches = TOTAL_W'(tot_n_match);
        s.covered   = TOTAL_W'(tot_cov);
        s.identity  = identity_pct(tot_edits, sext(tot_len));
        if (den <= 0) begin
          s.cov_bad = 1'b1;
        end else begin
          r = floor_div(200 * sext(tot_cov) + den, 2 * den);
          if (r < 0) r = 0;
          if (r > 65535) r = 65535;
          s.coverage = r[PCT_COV_W-1:0];
        end
        tot_edits   = '0;
        tot_n_match = '0;
        tot_match   = '0;
        tot_len     = '0;
        tot_cov     = '0;
      end
    endcase
    return s;
  endfunction

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ex_edits    = '0;
      ex_n_match  = '0;
      ex_match    = '0;
      tot_edits   = '0;
      tot_n_match = '0;
      tot_match   = '0;
      tot_len     = '0;
      tot_cov     = '0;
      score_q.delete();
    end else begin
      // Results are checked before new items are queued: no result can
      // belong to an item accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (score_q.size() == 0) begin
          $error("result transfer of kind %0d with no expectation waiting", out_result_kind);
          fail_count++;
        end else begin
          want = score_q.pop_front();
          results_seen++;
          check_field("result_kind", want.kind, out_result_kind);
          check_field("column_class", want.cls, out_column_class);
          check_field("query_char_out", want.q_chr, out_query_char_out);
          check_field("genome_char_out", want.g_chr, out_genome_char_out);
          check_field("match_total", want.match_cnt, out_match_total);
          check_field("n_match_total", want.n_matches, out_n_match_total);
          check_field("covered_total", want.covered, out_covered_total);
          check_field("identity_percent", longint'($signed(want.identity)),
                      longint'(out_identity_percent));
          check_field("coverage_percent", want.coverage, out_coverage_percent);
          check_field("coverage_invalid", want.cov_bad, out_coverage_invalid);
        end
      end
      if (in_valid && !in_stall && kind_t'(in_kind) != KIND_NONE) begin
        score_q.push_back(predict_score());
      end
    end
    pending = score_q.size();
  end

endmodule

[bench/alignment_identity_scorer_core_tb.sv]
// Testbench top for the alignment identity scorer: drives items and result
// back-pressure and gives the verdict. Needs asc_pkg, the block and
// asc_score_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module alignment_identity_scorer_core_tb
  import asc_pkg::*;
;

  // Number of random item transfers after the directed part.
  localparam int N_RANDOM = 1500;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 in_kind;
  logic [7:0]                 in_query_char;
  logic [7:0]                 in_genome_char;
  logic [31:0]                in_genome_from;
  logic [31:0]                in_genome_to;
  logic [31:0]                in_query_from;
  logic [31:0]                in_query_to;
  logic [31:0]                in_query_length;
  logic [31:0]                in_poly_a_length;
  logic [31:0]                in_poly_t_length;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 out_result_kind;
  logic [2:0]                 out_column_class;
  logic [7:0]                 out_query_char_out;
  logic [7:0]                 out_genome_char_out;
  logic [TOTAL_W-1:0]         out_match_total;
  logic [TOTAL_W-1:0]         out_n_match_total;
  logic [TOTAL_W-1:0]         out_covered_total;
  logic signed [PCT_ID_W-1:0] out_identity_percent;
  logic [PCT_COV_W-1:0]       out_coverage_percent;
  logic                       out_coverage_invalid;

  int fail_count;
  int pending;
  int results_seen;

  // Transfer tallies for the closing summary.
  int n_columns;
  int n_exons;
  int n_aligns;
  int n_ignored;

  // When set, the sender leaves no gaps between transfers.
  logic back_to_back;

  alignment_identity_scorer_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_query_char        (in_query_char),
    .in_genome_char       (in_genome_char),
    .in_genome_from       (in_genome_from),
    .in_genome_to         (in_genome_to),
    .in_query_from        (in_query_from),
    .in_query_to          (in_query_to),
    .in_query_length      (in_query_length),
    .in_poly_a_length     (in_poly_a_length),
    .in_poly_t_length     (in_poly_t_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_column_class     (out_column_class),
    .out_query_char_out   (out_query_char_out),
    .out_genome_char_out  (out_genome_char_out),
    .out_match_total      (out_match_total),
    .out_n_match_total    (out_n_match_total),
    .out_covered_total    (out_covered_total),
    .out_identity_percent (out_identity_percent),
    .out_coverage_percent (out_coverage_percent),
    .out_coverage_invalid (out_coverage_invalid)
  );

  asc_score_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_query_char        (in_query_char),
    .in_genome_char       (in_genome_char),
    .in_genome_from       (in_genome_from),
    .in_genome_to         (in_genome_to),
    .in_query_from        (in_query_from),
    .in_query_to          (in_query_to),
    .in_query_length      (in_query_length),
    .in_poly_a_length     (in_poly_a_length),
    .in_poly_t_length     (in_poly_t_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_column_class     (out_column_class),
    .out_query_char_out   (out_query_char_out),
    .out_genome_char_out  (out_genome_char_out),
    .out_match_total      (out_match_total),
    .out_n_match_total    (out_n_match_total),
    .out_covered_total    (out_covered_total),
    .out_identity_percent (out_identity_percent),
    .out_coverage_percent (out_coverage_percent),
    .out_coverage_invalid (out_coverage_invalid),
    .fail_count           (fail_count),
    .pending              (pending),
    .results_seen         (results_seen)
  );

  // 20 ns clock period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (back_to_back || sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Characters are mostly IUPAC codes in either case, with gaps, N and
  // arbitrary bytes mixed in so that every bit of the field moves.
  function automatic logic [7:0] pick_char();
    string      codes;
    logic [7:0] c;
    int         sel;
    codes = "ACGTURYSWKMBDHVN";
    sel   = $urandom_range(0, 99);
    if (sel < 60) begin
      c = codes[$urandom_range(0, 15)];
      return $urandom_range(0, 1) ? (c | 8'h20) : c;
    end
    if (sel < 70) return "-";
    if (sel < 80) return $urandom_range(0, 1) ? "n" : "N";
    return 8'($urandom_range(0, 255));
  endfunction

  // One transfer on the input channel: the item is presented at a falling
  // edge, held until a rising edge sees no stall, then followed by a gap.
  task automatic send_item(kind_t kind, logic [7:0] q, logic [7:0] g,
                           logic [31:0] gf, logic [31:0] gt,
                           logic [31:0] qf, logic [31:0] qt,
                           logic [31:0] ql, logic [31:0] pa, logic [31:0] pt);
    int gap;
    @(negedge clk);
    in_kind          = kind;
    in_query_char    = q;
    in_genome_char   = g;
    in_genome_from   = gf;
    in_genome_to     = gt;
    in_query_from    = qf;
    in_query_to      = qt;
    in_query_length  = ql;
    in_poly_a_length = pa;
    in_poly_t_length = pt;
    in_valid         = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (kind)
      KIND_COLUMN: n_columns++;
      KIND_EXON:   n_exons++;
      KIND_ALIGN:  n_aligns++;
      default:     n_ignored++;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Fields that an item kind does not use are filled with random values.
  task automatic send_column(logic [7:0] q, logic [7:0] g);
    send_item(KIND_COLUMN, q, g, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  task automatic send_exon(logic [31:0] gf, logic [31:0] gt, logic [31:0] qf,
                           logic [31:0] qt);
    send_item(KIND_EXON, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              gf, gt, qf, qt, $urandom, $urandom, $urandom);
  endtask

  task automatic send_align(logic [31:0] ql, logic [31:0] pa, logic [31:0] pt);
    send_item(KIND_ALIGN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              $urandom, $urandom, $urandom, $urandom, ql, pa, pt);
  endtask

  // An item with every field random, the unused kind included.
  task automatic send_noise();
    send_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  // Holds the sender off until every expected result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result back-pressure: bursts of stall of mixed length, with the odd
  // long stretch where results flow freely.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(50, 200)) @(negedge clk);
      end else begin
        @(negedge clk);
        out_stall = 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 50)) @(negedge clk);
        else repeat ($urandom_range(0, 3)) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          start_count;
    int          n_exon;
    int          n_col;
    int          span;
    int          sel;
    logic [31:0] cov_sum;
    logic [31:0] gf, qf, pa, pt;
    logic [7:0]  c;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_COLUMN;
    in_query_char    = '0;
    in_genome_char   = '0;
    in_genome_from   = '0;
    in_genome_to     = '0;
    in_query_from    = '0;
    in_query_to      = '0;
    in_query_length  = '0;
    in_poly_a_length = '0;
    in_poly_t_length = '0;
    back_to_back     = 1'b0;
    n_columns        = 0;
    n_exons          = 0;
    n_aligns         = 0;
    n_ignored        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Every column class, gaps on either side, N in both
    // cases, IUPAC ambiguity and U against T, and bytes outside the code set.
    send_column("-", "A");
    send_column("C", "-");
    send_column("-", "-");
    send_column("N", "n");
    send_column("n", "G");
    send_column("T", "N");
    send_column("a", "A");
    send_column("R", "g");
    send_column("U", "t");
    send_column("A", "C");
    send_column(8'h00, 8'h00);
    send_column(8'hFF, "n");
    // Eight edits against an exon length of one: identity saturates low.
    send_exon(32'd5, 32'd0, 32'd5, 32'd1);
    // An empty exon of length zero gives an identity of zero.
    send_exon(32'd10, 32'd9, 32'd10, 32'd9);
    // Extreme coordinates whose spans cancel out to a length of two.
    send_exon(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    // Zero coverage denominator sets the invalid flag.
    send_align(32'd10, 32'd5, 32'd5);
    send_item(KIND_NONE, 8'hFF, 8'hFF, '1, '1, '1, '1, '1, '1, '1);
    send_exon(32'd0, 32'd999, 32'd0, 32'd999);
    // A one-base query against 1000 covered bases saturates coverage high.
    send_align(32'd1, 32'd0, 32'd0);
    // A reversed exon leaves a negative covered count: coverage clamps to 0.
    send_exon(32'd1000, 32'd0, 32'd0, 32'd0);
    send_align(32'd100, 32'd0, 32'd0);
    // Tails longer than the query: negative denominator.
    send_align(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_align(32'hFFFF_FFFF, 32'd0, 32'd0);
    drain();

    // Random part: whole alignments of a few exons each with random content,
    // broken now and then by noise items and malformed closes.
    start_count = n_columns + n_exons + n_aligns;
    while (n_columns + n_exons + n_aligns - start_count < N_RANDOM) begin
      back_to_back = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) drain();
      n_exon  = $urandom_range(1, 4);
      cov_sum = '0;
      for (int e = 0; e < n_exon; e++) begin
        n_col = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 30);
        for (int k = 0; k < n_col; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 3) begin
            send_noise();
          end else if (sel < 68) begin
            c = pick_char();
            send_column($urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hDF),
                        $urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hDF));
          end else begin
            send_column(pick_char(), pick_char());
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          send_exon($urandom, $urandom, $urandom, $urandom);
        end else begin
          span    = n_col + $urandom_range(0, 2);
          gf      = $urandom_range(0, 32'h7FFF_FFFF);
          qf      = $urandom_range(0, 32'h00FF_FFFF);
          cov_sum = cov_sum + span;
          send_exon(gf, gf + span - 1, qf, qf + n_col - 1 + $urandom_range(0, 2));
        end
      end
      sel = $urandom_range(0, 99);
      pa  = $urandom_range(0, 20);
      pt  = $urandom_range(0, 20);
      if (sel < 75) send_align(cov_sum + pa + pt + $urandom_range(0, 10), pa, pt);
      else if (sel < 85) send_align(pa + pt - $urandom_range(0, 3), pa, pt);
      else if (sel < 95) send_align($urandom, $urandom, $urandom);
      else send_align(pa + pt + 1, pa, pt);
    end

    drain();
    // Let any late or spurious result show itself before the verdict.
    repeat (40) @(negedge clk);
    $display("Drove %0d column, %0d exon-close, %0d alignment-close and %0d ignored items.",
             n_columns, n_exons, n_aligns, n_ignored);
    $display("Checked %0d results under random stalls; %0d field mismatches.",
             results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
